/* rtl/spq_pkg.sv */
// Package for the sorted priority queue.
// Holds sizes, command codes and FSM state codes for the top level and its bench.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_SCAN = 3'd1;
  localparam logic [ST_W-1:0] ST_PUT  = 3'd2;
  localparam logic [ST_W-1:0] ST_TOP  = 3'd3;
  localparam logic [ST_W-1:0] ST_OUT  = 3'd4;

endpackage

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted max-priority queue: FSM walking a descending-order entry RAM.
// Depends on spq_pkg and spq_ram.
//
//   channel | valid      | stall       | payload
//   in      | in_valid_i | in_stall_o  | command_i, value_i
//   out     | out_valid_o| out_stall_i | accepted_o, top_valid_o, top_value_o, entry_count_o
//
// Each beat does one RAM read per stored entry visited, then a read of entry 0
// for the top value; an insert when full or a remove when empty skips the walk,
// and a remove of an absent value scans every entry.
// Insert walks from the tail shifting entries down; remove walks from the head
// closing the gap behind the first match.
// Reset clears count, FSM and output valid; RAM contents are not cleared.
// A result held by out_stall_i does not block the next input beat; only the
// final output load waits.
`default_nettype none

module sorted_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        command_i,
  input  wire logic signed [31:0] value_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        accepted_o,
  output      logic        top_valid_o,
  output      logic signed [31:0] top_value_o,
  output      logic [4:0]  entry_count_o
);

  localparam int unsigned AW = spq_pkg::ADDR_W;
  localparam int unsigned CW = spq_pkg::CNT_W;
  localparam int unsigned DW = spq_pkg::DATA_W;

  logic [spq_pkg::ST_W-1:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cmd_q, cmd_d;
  logic [DW-1:0] val_q, val_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          found_q, found_d;
  logic          ok_q, ok_d;

  logic          out_valid_q, out_valid_d;
  logic          acc_q, acc_d;
  logic          topv_q, topv_d;
  logic [DW-1:0] topval_q, topval_d;
  logic [CW-1:0] ocnt_q, ocnt_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic          in_beat, out_free, match, last;

  spq_ram #(
    .DEPTH (spq_pkg::CAPACITY),
    .WIDTH (DW),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o = (state_q != spq_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign match      = (rdata == val_q);
  assign last       = ({{(CW-AW){1'b0}}, addr_q} == (cnt_q - CW'(1)));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    addr_d      = addr_q;
    found_d     = found_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    acc_d       = acc_q;
    topv_d      = topv_q;
    topval_d    = topval_q;
    ocnt_d      = ocnt_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    wdata       = val_q;

    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_beat) begin
          cmd_d   = command_i;
          val_d   = value_i;
          found_d = 1'b0;
          ok_d    = 1'b0;
          if (command_i == spq_pkg::CMD_INSERT) begin
            if (cnt_q == CW'(spq_pkg::CAPACITY)) begin
              state_d = spq_pkg::ST_TOP;
            end else if (cnt_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = value_i;
              cnt_d   = CW'(1);
              ok_d    = 1'b1;
              state_d = spq_pkg::ST_TOP;
            end else begin
              re      = 1'b1;
              raddr   = AW'(cnt_q - CW'(1));
              addr_d  = raddr;
              state_d = spq_pkg::ST_SCAN;
            end
          end else begin
            if (cnt_q == '0) begin
              state_d = spq_pkg::ST_TOP;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              addr_d  = '0;
              state_d = spq_pkg::ST_SCAN;
            end
          end
        end
      end
      spq_pkg::ST_SCAN: begin
        if (cmd_q == spq_pkg::CMD_INSERT) begin
          we    = 1'b1;
          waddr = addr_q + AW'(1);
          if ($signed(rdata) < $signed(val_q)) begin
            wdata = rdata;
            if (addr_q == '0) begin
              state_d = spq_pkg::ST_PUT;
            end else begin
              re     = 1'b1;
              raddr  = addr_q - AW'(1);
              addr_d = raddr;
            end
          end else begin
            wdata   = val_q;
            cnt_d   = cnt_q + CW'(1);
            ok_d    = 1'b1;
            state_d = spq_pkg::ST_TOP;
          end
        end else begin
          if (found_q) begin
            we    = 1'b1;
            waddr = addr_q - AW'(1);
            wdata = rdata;
          end
          if (last) begin
            if (found_q || match) begin
              cnt_d = cnt_q - CW'(1);
              ok_d  = 1'b1;
            end
            state_d = spq_pkg::ST_TOP;
          end else begin
            found_d = found_q || match;
            re      = 1'b1;
            raddr   = addr_q + AW'(1);
            addr_d  = raddr;
          end
        end
      end
      spq_pkg::ST_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        cnt_d   = cnt_q + CW'(1);
        ok_d    = 1'b1;
        state_d = spq_pkg::ST_TOP;
      end
      spq_pkg::ST_TOP: begin
        re      = 1'b1;
        raddr   = '0;
        state_d = spq_pkg::ST_OUT;
      end
      spq_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          acc_d       = ok_q;
          topv_d      = (cnt_q != '0);
          topval_d    = (cnt_q != '0) ? rdata : '0;
          ocnt_d      = cnt_q;
          state_d     = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    addr_q   <= addr_d;
    found_q  <= found_d;
    ok_q     <= ok_d;
    acc_q    <= acc_d;
    topv_q   <= topv_d;
    topval_q <= topval_d;
    ocnt_q   <= ocnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign top_valid_o   = topv_q;
  assign top_value_o   = topval_q;
  assign entry_count_o = spq_pkg::COUNT_OUT_W'(ocnt_q);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("RAM read and write to the same entry in one cycle");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CW'(1)) ||
                                 (cnt_q + CW'(1) == $past(cnt_q))))
    else $error("entry count moved by more than one");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !top_valid_o) |-> (top_value_o == '0))
    else $error("nonzero top value on an empty queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::ST_OUT && !out_free) |=> (state_q == spq_pkg::ST_OUT))
    else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

/* rtl/spq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data is registered and holds while no read is issued. No package use.
`default_nettype none

module spq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* bench/spq_checker.sv */
// Checker for the sorted priority queue: watches both channels, keeps a shadow
// of the sorted store, and compares every output beat with the expected result.
// Depends on spq_pkg.
`default_nettype none

module spq_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               command_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               accepted_i,
  input  wire logic               top_valid_i,
  input  wire logic signed [31:0] top_value_i,
  input  wire logic [4:0]         entry_count_i,
  output int                      pending_o,
  output int                      fail_count_o
);

  typedef struct packed {
    logic               accepted;
    logic               top_valid;
    logic signed [31:0] top_value;
    logic [4:0]         entry_count;
  } queue_result_t;

  logic signed [spq_pkg::DATA_W-1:0] shadow_vals [spq_pkg::CAPACITY];
  int                       shadow_count = 0;
  queue_result_t            result_q[$];
  int                       errors = 0;

  // Apply one command to the shadow store and return the result it causes.
  function automatic queue_result_t apply_command(input logic cmd,
                                                  input logic signed [31:0] val);
    queue_result_t r;
    int            pos;
    logic          ok;
    pos = 0;
    ok  = 1'b0;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (shadow_count < spq_pkg::CAPACITY) begin
        while (pos < shadow_count && shadow_vals[pos] >= val) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = val;
        shadow_count++;
        ok = 1'b1;
      end
    end else begin
      while (pos < shadow_count && shadow_vals[pos] != val) pos++;
      if (pos < shadow_count) begin
        for (int i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_count--;
        ok = 1'b1;
      end
    end
    r.accepted    = ok;
    r.top_valid   = (shadow_count > 0);
    r.top_value   = (shadow_count > 0) ? shadow_vals[0] : '0;
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      result_q.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.accepted    = accepted_i;
        got.top_valid   = top_valid_i;
        got.top_value   = top_value_i;
        got.entry_count = entry_count_i;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: result beat with none expected: acc=%0b tv=%0b top=%0d cnt=%0d",
                     got.accepted, got.top_valid, got.top_value, got.entry_count);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp acc=%0b tv=%0b top=%0d cnt=%0d, got acc=%0b tv=%0b top=%0d cnt=%0d",
                       want.accepted, want.top_valid, want.top_value, want.entry_count,
                       got.accepted, got.top_valid, got.top_value, got.entry_count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(apply_command(command_i, value_i));
      pending_o    <= result_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

`default_nettype wire

/* bench/sorted_priority_queue_tb.sv */
// Testbench top for the sorted priority queue: clock, reset, command stimulus,
// output stall pattern and verdict. Depends on spq_pkg, spq_checker and the RTL.
`default_nettype none

module sorted_priority_queue_tb;

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 900;
  localparam int DRAIN_AT     = 1000;
  localparam int HOLD_AT      = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = spq_pkg::CMD_INSERT;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               accepted_o;
  logic               top_valid_o;
  logic signed [31:0] top_value_o;
  logic [4:0]         entry_count_o;

  int pending;
  int fail_count;
  int sent_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic signed [31:0] recent_q[$];
  wire quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

  always #5 clk_i = ~clk_i;

  sorted_priority_queue dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .command_i, .value_i,
    .out_valid_o, .out_stall_i,
    .accepted_o, .top_valid_o, .top_value_o, .entry_count_o
  );

  spq_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .accepted_i(accepted_o), .top_valid_i(top_valid_o),
    .top_value_i(top_value_o), .entry_count_i(entry_count_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

  // Receiver: random stalls but none when quiet, one long hold deep in the run.
  always @(posedge clk_i) begin
    if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 17);
    end
  end

  task automatic send_beat(input logic cmd, input logic signed [31:0] val);
    if (!quiet) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count <= sent_count + 1;
    if (cmd == spq_pkg::CMD_INSERT) begin
      recent_q.push_back(val);
      if (recent_q.size() > 24) void'(recent_q.pop_front());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] insert_value();
    int                 roll;
    logic signed [31:0] v;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(4))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = 0;
        3:       v = -1;
        default: v = 1;
      endcase
    end else if (roll < 30 && recent_q.size() > 0) begin
      v = recent_q[$urandom_range(recent_q.size() - 1)];
    end else if (roll < 45) begin
      v = $signed($urandom_range(15)) - 8;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic signed [31:0] remove_value();
    logic signed [31:0] v;
    if (recent_q.size() > 0 && $urandom_range(99) < 75)
      v = recent_q[$urandom_range(recent_q.size() - 1)];
    else if ($urandom_range(1))
      v = $signed($urandom_range(15)) - 8;
    else
      v = $urandom;
    return v;
  endfunction

  initial begin
    int insert_pct;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, duplicates, extremes, fill, full, absent
    send_beat(spq_pkg::CMD_REMOVE, 5);
    send_beat(spq_pkg::CMD_INSERT, 7);
    send_beat(spq_pkg::CMD_INSERT, 7);
    send_beat(spq_pkg::CMD_REMOVE, 7);
    send_beat(spq_pkg::CMD_INSERT, VAL_MIN);
    send_beat(spq_pkg::CMD_INSERT, VAL_MAX);
    send_beat(spq_pkg::CMD_INSERT, 0);
    send_beat(spq_pkg::CMD_INSERT, -1);
    for (int i = 0; i < 11; i++) send_beat(spq_pkg::CMD_INSERT, (i % 4) * 1000 - 1500);
    send_beat(spq_pkg::CMD_INSERT, 42);
    send_beat(spq_pkg::CMD_REMOVE, 12345);
    send_beat(spq_pkg::CMD_REMOVE, VAL_MAX);
    send_beat(spq_pkg::CMD_REMOVE, VAL_MIN);

    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      if ($urandom_range(99) < insert_pct) send_beat(spq_pkg::CMD_INSERT, insert_value());
      else                                 send_beat(spq_pkg::CMD_REMOVE, remove_value());
      if (n == DRAIN_AT) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule

`default_nettype wire
